@@ hdl/hkct_pkg.sv @@
// shared types and constants for the hashed key counter table
// no dependencies
package hkct_pkg;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_FIND  = 2'd1;
   localparam logic [1:0] OP_SET   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [31:0] HASH_FACTOR = 32'd2654435761;
   localparam int          HASH_SHIFT  = 10;
   localparam int          RSP_IDX_W   = 12;

   typedef struct packed {
      logic [31:0]          count;
      logic [RSP_IDX_W-1:0] entry_index;
      logic                 inserted;
      logic                 table_full;
   } rsp_type;

   localparam int RSP_W = $bits(rsp_type);

endpackage

@@ hdl/hashed_key_counter_table.sv @@
// top level of the hashed key counter table
// depends on hkct_pkg, hkct_front, hkct_fifo, hkct_engine, hkct_ram

// Counts 32-bit keys in a chained hash table. A request transfer carries an
// opcode (add, find, set count, clear), a key and a count value; each request
// gives exactly one result transfer with the count, the entry index, an
// inserted flag and a table full flag, in request order. The bucket is bits
// [10 +: BUCKET_BITS] of key * 2654435761. The front stage hashes the key and
// hands it to a two-deep command queue; the engine behind it takes one command
// at a time: it reads the bucket head, then follows the chain one entry at a
// time, and the insert or count update is written in the last step of that
// walk, unless the table is full. Clear, and reset, run a sweep over all
// 2^BUCKET_BITS bucket head entries during which no command is started;
// requests still queue up in front. Results wait in a two-deep result queue,
// so the engine keeps working while the consumer stalls, until that queue
// is full.
module hashed_key_counter_table #(
   parameter int BUCKET_BITS = 12,
   parameter int ENTRIES     = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_key,
   input  logic [31:0] req_new_count,
   output logic        req_full,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_count,
   output logic [11:0] rsp_entry_index,
   output logic        rsp_inserted,
   output logic        rsp_table_full
);

   // command word: opcode, key, new count, bucket
   localparam int CMD_W = 66 + BUCKET_BITS;

   logic                       fq_push, fq_full, fq_pop, fq_empty;
   logic [CMD_W-1:0]           fq_push_data, fq_pop_data;
   logic                       rq_push, rq_full;
   hkct_pkg::rsp_type          rq_push_data, rq_pop_data;
   logic [hkct_pkg::RSP_W-1:0] rq_pop_bits;

   // front: request transfer and hashing
   hkct_front #(.BUCKET_BITS(BUCKET_BITS), .CMD_W(CMD_W)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_opcode    (req_opcode),
      .req_key       (req_key),
      .req_new_count (req_new_count),
      .req_full      (req_full),
      .cmd_push      (fq_push),
      .cmd_data      (fq_push_data),
      .cmd_full      (fq_full)
   );

   // command queue between front and engine
   hkct_fifo #(.WIDTH(CMD_W), .DEPTH(2)) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (fq_push),
      .push_data (fq_push_data),
      .full      (fq_full),
      .pop       (fq_pop),
      .pop_data  (fq_pop_data),
      .empty     (fq_empty)
   );

   // engine: chain walk and table update
   hkct_engine #(.BUCKET_BITS(BUCKET_BITS), .ENTRIES(ENTRIES), .CMD_W(CMD_W)) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (fq_empty),
      .cmd_data  (fq_pop_data),
      .cmd_pop   (fq_pop),
      .rsp_full  (rq_full),
      .rsp_push  (rq_push),
      .rsp_data  (rq_push_data)
   );

   // result queue feeding the result ports
   hkct_fifo #(.WIDTH(hkct_pkg::RSP_W), .DEPTH(2)) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rq_push),
      .push_data (rq_push_data),
      .full      (rq_full),
      .pop       (rsp_pop),
      .pop_data  (rq_pop_bits),
      .empty     (rsp_empty)
   );

   assign rq_pop_data     = hkct_pkg::rsp_type'(rq_pop_bits);
   assign rsp_count       = rq_pop_data.count;
   assign rsp_entry_index = rq_pop_data.entry_index;
   assign rsp_inserted    = rq_pop_data.inserted;
   assign rsp_table_full  = rq_pop_data.table_full;

endmodule

@@ hdl/hkct_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module hkct_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/hkct_fifo.sv @@
// small register fifo used between front, engine and result ports
// no dependencies
module hkct_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/hkct_front.sv @@
// front end: takes request transfers, hashes the key, feeds the command queue
// depends on hkct_pkg
module hkct_front #(
   parameter int BUCKET_BITS = 12,
   parameter int CMD_W       = 66 + BUCKET_BITS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic [1:0]       req_opcode,
   input  logic [31:0]      req_key,
   input  logic [31:0]      req_new_count,
   output logic             req_full,
   output logic             cmd_push,
   output logic [CMD_W-1:0] cmd_data,
   input  logic             cmd_full
);

   logic        valid_ff, valid_in;
   logic [1:0]  op_ff;
   logic [31:0] key_ff, nc_ff, product;
   logic        take;

   assign req_full = valid_ff && cmd_full;
   assign take     = req_push && !req_full;
   assign cmd_push = valid_ff && !cmd_full;

   // only the low 32 product bits reach the bucket field
   assign product  = key_ff * hkct_pkg::HASH_FACTOR;
   assign cmd_data = {op_ff, key_ff, nc_ff,
                      product[hkct_pkg::HASH_SHIFT +: BUCKET_BITS]};

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (cmd_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         op_ff  <= req_opcode;
         key_ff <= req_key;
         nc_ff  <= req_new_count;
      end
   end

endmodule

@@ hdl/hkct_engine.sv @@
// back end: chain walk, insert, count update and bucket head clearing sweep
// depends on hkct_pkg and hkct_ram
module hkct_engine #(
   parameter int BUCKET_BITS = 12,
   parameter int ENTRIES     = 4096,
   parameter int CMD_W       = 66 + BUCKET_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  logic [CMD_W-1:0]      cmd_data,
   output logic                  cmd_pop,
   input  logic                  rsp_full,
   output logic                  rsp_push,
   output hkct_pkg::rsp_type     rsp_data
);

   localparam int IDX_W   = $clog2(ENTRIES);
   localparam int ENT_W   = 64 + IDX_W;
   localparam int BUCKETS = 1 << BUCKET_BITS;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_HEAD  = 2'd1;
   localparam logic [1:0] S_WALK  = 2'd2;
   localparam logic [1:0] S_SWEEP = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [BUCKET_BITS-1:0] sweep_ff, sweep_in;
   logic [IDX_W-1:0]       used_ff, used_in;
   logic [IDX_W-1:0]       cur_ff, cur_in, head_ff, head_in;
   logic [1:0]             op_ff;
   logic [31:0]            key_ff, nc_ff;
   logic [BUCKET_BITS-1:0] bucket_ff;

   logic [1:0]             cmd_op;
   logic [31:0]            cmd_key, cmd_nc;
   logic [BUCKET_BITS-1:0] cmd_bucket;

   logic                   head_we;
   logic [BUCKET_BITS-1:0] head_waddr, head_raddr;
   logic [IDX_W-1:0]       head_wdata, head_rdata;
   logic                   ent_we;
   logic [IDX_W-1:0]       ent_waddr, ent_raddr;
   logic [ENT_W-1:0]       ent_wdata, ent_rdata;

   logic [31:0]            ent_key, ent_cnt;
   logic [IDX_W-1:0]       ent_link, new_idx, head_now;
   logic                   is_hit, is_miss, tbl_full;

   function automatic logic [31:0] upd_count(input logic [1:0] op, input logic [31:0] c,
                                             input logic [31:0] nc);
      logic [31:0] r;
      r = c;
      if (op == hkct_pkg::OP_ADD && c != 32'hFFFF_FFFF) begin
         r = c + 32'd1;
      end else if (op == hkct_pkg::OP_SET) begin
         r = nc;
      end
      return r;
   endfunction

   function automatic logic [hkct_pkg::RSP_IDX_W-1:0] idx12(input logic [IDX_W-1:0] i);
      logic [IDX_W+hkct_pkg::RSP_IDX_W-1:0] e;
      e = {{hkct_pkg::RSP_IDX_W{1'b0}}, i};
      return e[hkct_pkg::RSP_IDX_W-1:0];
   endfunction

   assign {cmd_op, cmd_key, cmd_nc, cmd_bucket} = cmd_data;
   assign ent_key  = ent_rdata[ENT_W-1 -: 32];
   assign ent_cnt  = ent_rdata[IDX_W +: 32];
   assign ent_link = ent_rdata[IDX_W-1:0];
   assign head_now = (state_ff == S_HEAD) ? head_rdata : head_ff;
   assign new_idx  = used_ff + 1'b1;
   assign tbl_full = (used_ff == IDX_W'(ENTRIES - 1));
   assign is_hit   = (state_ff == S_WALK) && (ent_key == key_ff);
   assign is_miss  = ((state_ff == S_HEAD) && (head_rdata == '0)) ||
                     ((state_ff == S_WALK) && !is_hit && (ent_link == '0));

   always_comb begin
      state_in   = state_ff;
      sweep_in   = sweep_ff;
      used_in    = used_ff;
      cur_in     = cur_ff;
      head_in    = head_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = '0;
      head_we    = 1'b0;
      head_waddr = bucket_ff;
      head_wdata = new_idx;
      head_raddr = cmd_bucket;
      ent_we     = 1'b0;
      ent_waddr  = new_idx;
      ent_wdata  = {key_ff, upd_count(op_ff, 32'd0, nc_ff), head_now};
      ent_raddr  = head_rdata;
      unique case (state_ff)
         S_IDLE: begin
            if (!cmd_empty && !rsp_full) begin
               cmd_pop = 1'b1;
               if (cmd_op == hkct_pkg::OP_CLEAR) begin
                  rsp_push = 1'b1;
                  used_in  = '0;
                  sweep_in = '0;
                  state_in = S_SWEEP;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD, S_WALK: begin
            if (is_hit) begin
               ent_we    = 1'b1;
               ent_waddr = cur_ff;
               ent_wdata = {key_ff, upd_count(op_ff, ent_cnt, nc_ff), ent_link};
               rsp_push  = 1'b1;
               rsp_data  = '{count: upd_count(op_ff, ent_cnt, nc_ff),
                             entry_index: idx12(cur_ff), inserted: 1'b0,
                             table_full: 1'b0};
               state_in  = S_IDLE;
            end else if (is_miss) begin
               rsp_push = 1'b1;
               state_in = S_IDLE;
               if (tbl_full) begin
                  rsp_data.table_full = 1'b1;
               end else begin
                  ent_we   = 1'b1;
                  head_we  = 1'b1;
                  used_in  = new_idx;
                  rsp_data = '{count: upd_count(op_ff, 32'd0, nc_ff),
                               entry_index: idx12(new_idx), inserted: 1'b1,
                               table_full: 1'b0};
               end
            end else begin
               // follow the chain one entry
               if (state_ff == S_HEAD) begin
                  head_in   = head_rdata;
                  ent_raddr = head_rdata;
                  cur_in    = head_rdata;
               end else begin
                  ent_raddr = ent_link;
                  cur_in    = ent_link;
               end
               state_in = S_WALK;
            end
         end
         S_SWEEP: begin
            head_we    = 1'b1;
            head_waddr = sweep_ff;
            head_wdata = '0;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == BUCKET_BITS'(BUCKETS - 1)) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      head_ff <= head_in;
      if (cmd_pop) begin
         op_ff     <= cmd_op;
         key_ff    <= cmd_key;
         nc_ff     <= cmd_nc;
         bucket_ff <= cmd_bucket;
      end
   end

   hkct_ram #(.WIDTH(IDX_W), .DEPTH(BUCKETS)) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   hkct_ram #(.WIDTH(ENT_W), .DEPTH(ENTRIES)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= IDX_W'(ENTRIES - 1))
      else $error("entry counter beyond table size");

   a_head_nonzero: assert property (@(posedge clock) disable iff (reset)
      (head_we && state_ff != S_SWEEP) |-> (head_wdata != '0))
      else $error("chain head written with empty index outside sweep");

   a_rsp_space: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");

   a_pop_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> (state_ff != S_IDLE))
      else $error("command taken but engine stayed idle");

endmodule
